// ===== src/cbrv_pkg.sv =====
// Shared types, constants and a helper function for the CAN batch record validator.
package cbrv_pkg;

  // Byte sizes of the batch header and of one record
  localparam int HEADER_BYTES = 16;
  localparam int RECORD_BYTES = 7;

  // Field widths
  localparam int LEN_W    = 16;
  localparam int COUNT_W  = 8;
  localparam int TIME_W   = 64;
  localparam int DT_W     = 16;
  localparam int IDENT_W  = 32;
  localparam int PLEN_W   = 8;
  localparam int ID_W     = 29;
  localparam int OFFSET_W = 17;
  // Offset arithmetic with one spare bit so a sum never wraps before compare
  localparam int SUM_W    = OFFSET_W + 1;
  // delta_ticks times ten fits in DT_W + 4 bits
  localparam int DT10_W   = DT_W + 4;

  // Identifier word layout
  localparam int EXT_BIT = 29;
  localparam int FD_BIT  = 30;
  localparam int RTR_BIT = 31;
  localparam logic [ID_W-1:0] STD_ID_MAX = ID_W'(32'h7FF);
  localparam logic [PLEN_W-1:0] CLASSIC_MAX_LEN = PLEN_W'(8);

  // Item kinds
  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_RECORD = 1'b1
  } op_t;

  // Per-record and per-batch status codes
  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_LENGTH   = 4'd1,
    ST_EMPTY    = 4'd2,
    ST_TRUNC    = 4'd3,
    ST_FIRST_DT = 4'd4,
    ST_STD_ID   = 4'd5,
    ST_FD_RTR   = 4'd6,
    ST_RTR_PAY  = 4'd7,
    ST_CLASSIC  = 4'd8,
    ST_FD_LEN   = 4'd9,
    ST_NO_BATCH = 4'd10
  } status_t;

  // Batch context the record checker needs
  typedef struct packed {
    logic                first_pending;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LEN_W-1:0]    batch_length;
  } ctx_t;

  // One result transaction
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   frame_id;
    logic              is_extended;
    logic              is_fd;
    logic              is_remote;
    logic [PLEN_W-1:0] frame_len;
    logic [TIME_W-1:0] frame_time;
    logic              last_of_batch;
    logic              batch_ok;
  } result_t;

  // CAN FD data length ladder: 0..8, 12, 16, 20, 24, 32, 48, 64
  function automatic logic fd_len_ok(input logic [PLEN_W-1:0] n);
    logic ok;
    case (n) inside
      [8'd0:8'd8], 8'd12, 8'd16, 8'd20, 8'd24, 8'd32, 8'd48, 8'd64: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== src/cbrv_check.sv =====
// Record checker: ordered validity checks and the byte offset after a good record.
module cbrv_check (
  input  cbrv_pkg::ctx_t                   ctx,
  input  logic [cbrv_pkg::DT_W-1:0]        delta_ticks,
  input  logic [cbrv_pkg::IDENT_W-1:0]     raw_ident,
  input  logic [cbrv_pkg::PLEN_W-1:0]      payload_len,
  output cbrv_pkg::status_t                status,
  output logic [cbrv_pkg::OFFSET_W-1:0]    next_offset
);

  logic                            ext;
  logic                            fd;
  logic                            rtr;
  logic [cbrv_pkg::SUM_W-1:0]      after;
  logic [cbrv_pkg::SUM_W-1:0]      total;
  logic [cbrv_pkg::SUM_W-1:0]      limit;

  assign ext = raw_ident[cbrv_pkg::EXT_BIT];
  assign fd  = raw_ident[cbrv_pkg::FD_BIT];
  assign rtr = raw_ident[cbrv_pkg::RTR_BIT];

  // Offsets at the end of the record header and of its payload
  assign after = {1'b0, ctx.byte_offset} + cbrv_pkg::SUM_W'(cbrv_pkg::RECORD_BYTES);
  assign total = after + cbrv_pkg::SUM_W'(payload_len);
  assign limit = cbrv_pkg::SUM_W'(ctx.batch_length);

  assign next_offset = total[cbrv_pkg::OFFSET_W-1:0];

  // First failing check wins
  always_comb begin
    if (after > limit) begin
      status = cbrv_pkg::ST_TRUNC;
    end else if (ctx.first_pending && (delta_ticks != '0)) begin
      status = cbrv_pkg::ST_FIRST_DT;
    end else if (!ext && (raw_ident[cbrv_pkg::ID_W-1:0] > cbrv_pkg::STD_ID_MAX)) begin
      status = cbrv_pkg::ST_STD_ID;
    end else if (fd && rtr) begin
      status = cbrv_pkg::ST_FD_RTR;
    end else if (rtr && (payload_len != '0)) begin
      status = cbrv_pkg::ST_RTR_PAY;
    end else if (!fd && (payload_len > cbrv_pkg::CLASSIC_MAX_LEN)) begin
      status = cbrv_pkg::ST_CLASSIC;
    end else if (fd && !cbrv_pkg::fd_len_ok(payload_len)) begin
      status = cbrv_pkg::ST_FD_LEN;
    end else if (total > limit) begin
      status = cbrv_pkg::ST_TRUNC;
    end else begin
      status = cbrv_pkg::ST_OK;
    end
  end

endmodule

// ===== src/cbrv_out_reg.sv =====
// Result register: holds one result transaction until the receiver takes it.
module cbrv_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cbrv_pkg::result_t res,
  input  logic              out_stall,
  output logic              valid,
  output cbrv_pkg::result_t res_q
);

  logic              valid_r;
  logic              valid_nxt;
  cbrv_pkg::result_t res_r;

  // Load replaces the held result; otherwise it clears once taken
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign valid = valid_r;
  assign res_q = res_r;

endmodule

// ===== src/can_batch_record_validator.sv =====
// Top level of the CAN batch record validator: batch state, result build, result register.
//
// Usage:
//   Input channel (in_valid / in_stall): a header transaction (in_op = 0) opens a batch
//   with its length, record count and base time; each record transaction (in_op = 1)
//   carries delta ticks, identifier word and payload length.
//   Result channel (out_valid / out_stall): one result per record, and one for a
//   rejected header; an accepted header gives none.
//   Output: a result is in the output register in the cycle after its item is accepted.
//   Throughput: one item per cycle while out_stall is low; the whole check and the 64-bit time add
//   sit between the input handshake and the single result register.
//   Stall: while a result waits with out_stall high, in_stall is high and no item is
//   taken; when the receiver takes the result, a new item can be taken in that same cycle.
//   Reset (rst_n low, synchronous): no batch open, all counters zero, result register
//   empty. A record with no open batch reports "no batch" and changes nothing.
//   Batch verdict: the final record carries last_of_batch, and batch_ok when no check
//   failed and the byte count matched the declared total exactly.
module can_batch_record_validator (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [cbrv_pkg::LEN_W-1:0]         in_batch_len,
  input  logic [cbrv_pkg::COUNT_W-1:0]       in_record_count,
  input  logic [cbrv_pkg::TIME_W-1:0]        in_base_time,
  input  logic [cbrv_pkg::DT_W-1:0]          in_delta_ticks,
  input  logic [cbrv_pkg::IDENT_W-1:0]       in_raw_ident,
  input  logic [cbrv_pkg::PLEN_W-1:0]        in_payload_len,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [3:0]                         out_status,
  output logic [cbrv_pkg::ID_W-1:0]          out_frame_id,
  output logic                               out_is_extended,
  output logic                               out_is_fd,
  output logic                               out_is_remote,
  output logic [cbrv_pkg::PLEN_W-1:0]        out_frame_len,
  output logic [cbrv_pkg::TIME_W-1:0]        out_frame_time,
  output logic                               out_last_of_batch,
  output logic                               out_batch_ok
);

  // Batch state
  logic                             batch_open_r,    batch_open_nxt;
  logic [cbrv_pkg::COUNT_W-1:0]     records_left_r,  records_left_nxt;
  logic [cbrv_pkg::OFFSET_W-1:0]    byte_offset_r,   byte_offset_nxt;
  logic [cbrv_pkg::LEN_W-1:0]       batch_length_r,  batch_length_nxt;
  logic [cbrv_pkg::TIME_W-1:0]      batch_time_r,    batch_time_nxt;
  logic                             first_pending_r, first_pending_nxt;
  cbrv_pkg::status_t                batch_error_r,   batch_error_nxt;

  logic                             accept;
  logic                             load;
  logic                             res_valid;
  cbrv_pkg::result_t                res;
  cbrv_pkg::result_t                res_q;
  cbrv_pkg::ctx_t                   ctx;
  cbrv_pkg::status_t                chk_status;
  logic [cbrv_pkg::OFFSET_W-1:0]    chk_offset;
  logic [cbrv_pkg::DT10_W-1:0]      dt_x10;
  logic                             last;

  // Take a new item whenever the result register is empty or being drained
  assign in_stall = res_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign ctx.first_pending = first_pending_r;
  assign ctx.byte_offset   = byte_offset_r;
  assign ctx.batch_length  = batch_length_r;

  cbrv_check u_check (
    .ctx         (ctx),
    .delta_ticks (in_delta_ticks),
    .raw_ident   (in_raw_ident),
    .payload_len (in_payload_len),
    .status      (chk_status),
    .next_offset (chk_offset)
  );

  // delta times ten as two shifted adds
  assign dt_x10 = ({4'b0, in_delta_ticks} << 3) + ({4'b0, in_delta_ticks} << 1);

  // Batch state update and result build
  always_comb begin
    batch_open_nxt    = batch_open_r;
    records_left_nxt  = records_left_r;
    byte_offset_nxt   = byte_offset_r;
    batch_length_nxt  = batch_length_r;
    batch_time_nxt    = batch_time_r;
    first_pending_nxt = first_pending_r;
    batch_error_nxt   = batch_error_r;
    res               = '0;
    load              = 1'b0;
    last              = 1'b0;

    if (accept) begin
      if (in_op == cbrv_pkg::OP_HEADER) begin
        // Header drops any open batch
        batch_open_nxt    = 1'b0;
        records_left_nxt  = '0;
        first_pending_nxt = 1'b0;
        batch_error_nxt   = cbrv_pkg::ST_OK;
        if (in_batch_len < cbrv_pkg::LEN_W'(cbrv_pkg::HEADER_BYTES)) begin
          load              = 1'b1;
          res.status        = cbrv_pkg::ST_LENGTH;
          res.last_of_batch = 1'b1;
        end else if (in_record_count == '0) begin
          load              = 1'b1;
          res.status        = cbrv_pkg::ST_EMPTY;
          res.last_of_batch = 1'b1;
        end else begin
          batch_open_nxt    = 1'b1;
          records_left_nxt  = in_record_count;
          byte_offset_nxt   = cbrv_pkg::OFFSET_W'(cbrv_pkg::HEADER_BYTES);
          batch_length_nxt  = in_batch_len;
          batch_time_nxt    = in_base_time;
          first_pending_nxt = 1'b1;
        end
      end else begin
        load            = 1'b1;
        res.frame_id    = in_raw_ident[cbrv_pkg::ID_W-1:0];
        res.is_extended = in_raw_ident[cbrv_pkg::EXT_BIT];
        res.is_fd       = in_raw_ident[cbrv_pkg::FD_BIT];
        res.is_remote   = in_raw_ident[cbrv_pkg::RTR_BIT];
        res.frame_len   = in_payload_len;
        if (!batch_open_r) begin
          res.status = cbrv_pkg::ST_NO_BATCH;
        end else begin
          res.frame_time = batch_time_r + cbrv_pkg::TIME_W'(dt_x10);
          // First error of the batch is latched; later records are not checked
          if (batch_error_r == cbrv_pkg::ST_OK) begin
            batch_error_nxt = chk_status;
            if (chk_status == cbrv_pkg::ST_OK) begin
              byte_offset_nxt = chk_offset;
            end
          end
          first_pending_nxt = 1'b0;
          if (records_left_r <= cbrv_pkg::COUNT_W'(1)) begin
            last             = 1'b1;
            records_left_nxt = '0;
            batch_open_nxt   = 1'b0;
            if ((batch_error_nxt == cbrv_pkg::ST_OK) &&
                (byte_offset_nxt != cbrv_pkg::OFFSET_W'(batch_length_r))) begin
              batch_error_nxt = cbrv_pkg::ST_LENGTH;
            end
          end else begin
            records_left_nxt = records_left_r - cbrv_pkg::COUNT_W'(1);
          end
          res.status        = batch_error_nxt;
          res.last_of_batch = last;
          res.batch_ok      = last && (batch_error_nxt == cbrv_pkg::ST_OK);
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_open_r    <= 1'b0;
      records_left_r  <= '0;
      byte_offset_r   <= '0;
      batch_length_r  <= '0;
      batch_time_r    <= '0;
      first_pending_r <= 1'b0;
      batch_error_r   <= cbrv_pkg::ST_OK;
    end else begin
      batch_open_r    <= batch_open_nxt;
      records_left_r  <= records_left_nxt;
      byte_offset_r   <= byte_offset_nxt;
      batch_length_r  <= batch_length_nxt;
      batch_time_r    <= batch_time_nxt;
      first_pending_r <= first_pending_nxt;
      batch_error_r   <= batch_error_nxt;
    end
  end

  cbrv_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .out_stall (out_stall),
    .valid     (res_valid),
    .res_q     (res_q)
  );

  assign out_valid         = res_valid;
  assign out_status        = res_q.status;
  assign out_frame_id      = res_q.frame_id;
  assign out_is_extended   = res_q.is_extended;
  assign out_is_fd         = res_q.is_fd;
  assign out_is_remote     = res_q.is_remote;
  assign out_frame_len     = res_q.frame_len;
  assign out_frame_time    = res_q.frame_time;
  assign out_last_of_batch = res_q.last_of_batch;
  assign out_batch_ok      = res_q.batch_ok;

  // A closed batch has no records outstanding
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !batch_open_r |-> (records_left_r == '0))
    else $error("records outstanding with no open batch");

  // While a batch is clean, the offset never passes the declared length
  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (batch_open_r && (batch_error_r == cbrv_pkg::ST_OK)) |->
      (byte_offset_r <= cbrv_pkg::OFFSET_W'(batch_length_r)))
    else $error("byte offset past batch length in a clean batch");

  // A passing verdict only comes with the last record and an ok status
  a_ok_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_batch_ok) |->
      (out_last_of_batch && (out_status == cbrv_pkg::ST_OK)))
    else $error("batch_ok without last record or with error status");

  // A held result is never overwritten by a new load
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_stall) |-> !load)
    else $error("result register loaded while stalled");

  // An accepted record with no batch never changes the batch state
  a_no_batch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == cbrv_pkg::OP_RECORD) && !batch_open_r) |=>
      (!batch_open_r && (records_left_r == '0)))
    else $error("record without batch changed batch state");

endmodule

// ===== verif/tb_can_batch_record_validator.sv =====
// Testbench for the CAN batch record validator: directed and random batches checked against a predictor.
`timescale 1ns / 100ps

module tb_can_batch_record_validator;

  localparam int RANDOM_ITEMS = 1850;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_WAIT     = 4;

  // One input transaction as the driver presents it
  typedef struct packed {
    cbrv_pkg::op_t                op;
    logic [cbrv_pkg::LEN_W-1:0]   batch_len;
    logic [cbrv_pkg::COUNT_W-1:0] record_count;
    logic [cbrv_pkg::TIME_W-1:0]  base_time;
    logic [cbrv_pkg::DT_W-1:0]    delta_ticks;
    logic [cbrv_pkg::IDENT_W-1:0] raw_ident;
    logic [cbrv_pkg::PLEN_W-1:0]  payload_len;
  } can_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_op = 1'b0;
  logic [cbrv_pkg::LEN_W-1:0]    in_batch_len = '0;
  logic [cbrv_pkg::COUNT_W-1:0]  in_record_count = '0;
  logic [cbrv_pkg::TIME_W-1:0]   in_base_time = '0;
  logic [cbrv_pkg::DT_W-1:0]     in_delta_ticks = '0;
  logic [cbrv_pkg::IDENT_W-1:0]  in_raw_ident = '0;
  logic [cbrv_pkg::PLEN_W-1:0]   in_payload_len = '0;

  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [3:0]                    out_status;
  logic [cbrv_pkg::ID_W-1:0]     out_frame_id;
  logic                          out_is_extended;
  logic                          out_is_fd;
  logic                          out_is_remote;
  logic [cbrv_pkg::PLEN_W-1:0]   out_frame_len;
  logic [cbrv_pkg::TIME_W-1:0]   out_frame_time;
  logic                          out_last_of_batch;
  logic                          out_batch_ok;

  can_batch_record_validator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_batch_len      (in_batch_len),
    .in_record_count   (in_record_count),
    .in_base_time      (in_base_time),
    .in_delta_ticks    (in_delta_ticks),
    .in_raw_ident      (in_raw_ident),
    .in_payload_len    (in_payload_len),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_frame_id      (out_frame_id),
    .out_is_extended   (out_is_extended),
    .out_is_fd         (out_is_fd),
    .out_is_remote     (out_is_remote),
    .out_frame_len     (out_frame_len),
    .out_frame_time    (out_frame_time),
    .out_last_of_batch (out_last_of_batch),
    .out_batch_ok      (out_batch_ok)
  );

  // Clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  can_item_t           outbound_items[$];
  cbrv_pkg::result_t   expected_frames[$];
  int                  mismatches = 0;
  int                  cycle_count = 0;

  // Predictor copy of the batch state
  logic                          open_batch = 1'b0;
  logic [cbrv_pkg::COUNT_W-1:0]  recs_left = '0;
  logic [cbrv_pkg::OFFSET_W-1:0] offset = '0;
  logic [cbrv_pkg::LEN_W-1:0]    batch_len_q = '0;
  logic [cbrv_pkg::TIME_W-1:0]   batch_base = '0;
  logic                          await_first = 1'b0;
  cbrv_pkg::status_t             latched_fault = cbrv_pkg::ST_OK;

  // Handshake flags sampled at the rising edge
  logic      in_taken = 1'b0;
  logic      out_taken = 1'b0;
  can_item_t cur_item = '0;
  int        in_gap = 0;
  int        stall_left = 0;
  logic      in_burst = 1'b0;
  logic      out_burst = 1'b0;

  function automatic can_item_t random_item(input cbrv_pkg::op_t kind);
    can_item_t it;
    it.op           = kind;
    it.batch_len    = cbrv_pkg::LEN_W'($urandom);
    it.record_count = cbrv_pkg::COUNT_W'($urandom);
    it.base_time    = {$urandom, $urandom};
    it.delta_ticks  = cbrv_pkg::DT_W'($urandom);
    it.raw_ident    = $urandom;
    it.payload_len  = cbrv_pkg::PLEN_W'($urandom);
    return it;
  endfunction

  task automatic add_hdr(input logic [cbrv_pkg::LEN_W-1:0] len,
                         input logic [cbrv_pkg::COUNT_W-1:0] cnt,
                         input logic [cbrv_pkg::TIME_W-1:0] base);
    can_item_t it;
    it = random_item(cbrv_pkg::OP_HEADER);
    it.batch_len    = len;
    it.record_count = cnt;
    it.base_time    = base;
    outbound_items.push_back(it);
  endtask

  task automatic add_rec(input logic [cbrv_pkg::DT_W-1:0] dt,
                         input logic [cbrv_pkg::IDENT_W-1:0] raw,
                         input logic [cbrv_pkg::PLEN_W-1:0] plen);
    can_item_t it;
    it = random_item(cbrv_pkg::OP_RECORD);
    it.delta_ticks = dt;
    it.raw_ident   = raw;
    it.payload_len = plen;
    outbound_items.push_back(it);
  endtask

  // Batch validation predictor: updates state, queues the expected result
  task automatic validate_item(input can_item_t it);
    cbrv_pkg::result_t          res;
    cbrv_pkg::status_t          fault;
    logic [cbrv_pkg::SUM_W-1:0] rec_end;
    logic [cbrv_pkg::SUM_W-1:0] pay_end;
    logic                       ext;
    logic                       fd;
    logic                       rtr;
    res = '0;
    if (it.op == cbrv_pkg::OP_HEADER) begin
      // any header drops an open batch without verdict
      open_batch    = 1'b0;
      recs_left     = '0;
      await_first   = 1'b0;
      latched_fault = cbrv_pkg::ST_OK;
      if (it.batch_len < cbrv_pkg::HEADER_BYTES || it.record_count == 0) begin
        if (it.batch_len < cbrv_pkg::HEADER_BYTES) res.status = cbrv_pkg::ST_LENGTH;
        else res.status = cbrv_pkg::ST_EMPTY;
        res.last_of_batch = 1'b1;
        expected_frames.push_back(res);
      end else begin
        open_batch  = 1'b1;
        recs_left   = it.record_count;
        offset      = cbrv_pkg::OFFSET_W'(cbrv_pkg::HEADER_BYTES);
        batch_len_q = it.batch_len;
        batch_base  = it.base_time;
        await_first = 1'b1;
      end
    end else begin
      ext = it.raw_ident[cbrv_pkg::EXT_BIT];
      fd  = it.raw_ident[cbrv_pkg::FD_BIT];
      rtr = it.raw_ident[cbrv_pkg::RTR_BIT];
      res.frame_id    = it.raw_ident[cbrv_pkg::ID_W-1:0];
      res.is_extended = ext;
      res.is_fd       = fd;
      res.is_remote   = rtr;
      res.frame_len   = it.payload_len;
      if (!open_batch) begin
        res.status = cbrv_pkg::ST_NO_BATCH;
      end else begin
        res.frame_time = batch_base + 64'(it.delta_ticks) * 64'd10;
        // only the first fault of a batch is checked and kept
        if (latched_fault == cbrv_pkg::ST_OK) begin
          rec_end = cbrv_pkg::SUM_W'(offset) + cbrv_pkg::SUM_W'(cbrv_pkg::RECORD_BYTES);
          pay_end = rec_end + cbrv_pkg::SUM_W'(it.payload_len);
          fault   = cbrv_pkg::ST_OK;
          if (rec_end > batch_len_q) fault = cbrv_pkg::ST_TRUNC;
          else if (await_first && it.delta_ticks != 0) fault = cbrv_pkg::ST_FIRST_DT;
          else if (!ext && it.raw_ident[cbrv_pkg::ID_W-1:0] > cbrv_pkg::STD_ID_MAX)
            fault = cbrv_pkg::ST_STD_ID;
          else if (fd && rtr) fault = cbrv_pkg::ST_FD_RTR;
          else if (rtr && it.payload_len != 0) fault = cbrv_pkg::ST_RTR_PAY;
          else if (!fd && it.payload_len > cbrv_pkg::CLASSIC_MAX_LEN)
            fault = cbrv_pkg::ST_CLASSIC;
          else if (fd && !(it.payload_len <= 8 || it.payload_len == 12 ||
                           it.payload_len == 16 || it.payload_len == 20 ||
                           it.payload_len == 24 || it.payload_len == 32 ||
                           it.payload_len == 48 || it.payload_len == 64))
            fault = cbrv_pkg::ST_FD_LEN;
          else if (pay_end > batch_len_q) fault = cbrv_pkg::ST_TRUNC;
          if (fault == cbrv_pkg::ST_OK) offset = pay_end[cbrv_pkg::OFFSET_W-1:0];
          else latched_fault = fault;
        end
        await_first = 1'b0;
        // final record: exact length check and verdict
        if (recs_left <= 1) begin
          recs_left = '0;
          res.last_of_batch = 1'b1;
          if (latched_fault == cbrv_pkg::ST_OK && offset != batch_len_q)
            latched_fault = cbrv_pkg::ST_LENGTH;
          open_batch = 1'b0;
        end else begin
          recs_left = recs_left - 1'b1;
        end
        res.status   = latched_fault;
        res.batch_ok = res.last_of_batch && (latched_fault == cbrv_pkg::ST_OK);
      end
      expected_frames.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [cbrv_pkg::TIME_W-1:0] want,
                             input logic [cbrv_pkg::TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: presents queued transactions with random gaps
  always @(negedge clk) begin : item_driver
    logic busy;
    busy = in_valid;
    if (!rst_n) begin
      busy = 1'b0;
    end else begin
      if (in_valid && in_taken) begin
        validate_item(cur_item);
        busy   = 1'b0;
        in_gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      end
      if (!busy) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (outbound_items.size() != 0) begin
          cur_item = outbound_items.pop_front();
          busy     = 1'b1;
        end
      end
    end
    in_valid        <= busy;
    in_op           <= cur_item.op;
    in_batch_len    <= cur_item.batch_len;
    in_record_count <= cur_item.record_count;
    in_base_time    <= cur_item.base_time;
    in_delta_ticks  <= cur_item.delta_ticks;
    in_raw_ident    <= cur_item.raw_ident;
    in_payload_len  <= cur_item.payload_len;
  end

  // Result side back-pressure
  always @(negedge clk) begin : result_sink
    if (out_taken) begin
      stall_left = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_monitor
    cbrv_pkg::result_t want;
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result: status %0d, frame_id 0x%0h", out_status, out_frame_id);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("status", want.status, out_status);
        check_field("frame_id", want.frame_id, out_frame_id);
        check_field("is_extended", want.is_extended, out_is_extended);
        check_field("is_fd", want.is_fd, out_is_fd);
        check_field("is_remote", want.is_remote, out_is_remote);
        check_field("frame_len", want.frame_len, out_frame_len);
        check_field("frame_time", want.frame_time, out_frame_time);
        check_field("last_of_batch", want.last_of_batch, out_last_of_batch);
        check_field("batch_ok", want.batch_ok, out_batch_ok);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    can_item_t rec;
    can_item_t recs[$];
    int        directed;
    int        n;
    int        k;
    int        keep;
    int        total;
    int        mode;
    int        pick;
    logic      ext_f;
    logic      fd_f;
    logic      rtr_f;
    logic [cbrv_pkg::LEN_W-1:0] hdr_len;

    // Directed: no batch, header rejects, one clean batch, each record fault
    add_rec(16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    add_hdr(16'd15, 8'd5, '0);
    add_hdr(16'd16, 8'd0, '0);
    add_hdr(16'd102, 8'd2, 64'hFFFF_FFFF_FFFF_FFFF);
    add_rec(16'd0, 32'h0000_07FF, 8'd8);
    add_rec(16'hFFFF, 32'h7FFF_FFFF, 8'd64);
    add_hdr(16'd100, 8'd2, {$urandom, $urandom});
    add_rec(16'd1, 32'h0000_0123, 8'd0);
    add_rec(16'd0, 32'h0000_0123, 8'd0);
    add_hdr(16'd23, 8'd1, '0);
    add_rec(16'd0, 32'h0000_0800, 8'd0);
    add_hdr(16'd23, 8'd1, '0);
    add_rec(16'd0, 32'hC000_0001, 8'd0);
    add_hdr(16'd24, 8'd1, '0);
    add_rec(16'd0, 32'h8000_0001, 8'd1);
    add_hdr(16'd32, 8'd1, '0);
    add_rec(16'd0, 32'h2000_0001, 8'd9);
    add_hdr(16'd100, 8'd1, '0);
    add_rec(16'd0, 32'h4000_0001, 8'd13);
    // truncated before the payload, then inside it
    add_hdr(16'd22, 8'd1, '0);
    add_rec(16'd0, 32'h0000_0001, 8'd0);
    add_hdr(16'd30, 8'd1, '0);
    add_rec(16'd0, 32'h0000_0001, 8'd8);
    // total longer than the records fill
    add_hdr(16'd40, 8'd1, '0);
    add_rec(16'd0, 32'h8000_0005, 8'd0);
    // batch left open; the next header drops it
    add_hdr(16'd200, 8'd3, {$urandom, $urandom});
    add_rec(16'd0, 32'h0000_0005, 8'd2);
    directed = outbound_items.size();

    // Random: mostly well-formed batches, some faults and noise
    while (outbound_items.size() < directed + RANDOM_ITEMS) begin
      mode = $urandom_range(0, 99);
      if (mode < 85) begin
        n = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
        total = cbrv_pkg::HEADER_BYTES;
        recs.delete();
        for (k = 0; k < n; k++) begin
          rec = random_item(cbrv_pkg::OP_RECORD);
          if ($urandom_range(0, 29) != 0) begin
            ext_f = 1'($urandom_range(0, 1));
            fd_f  = 1'($urandom_range(0, 1));
            rtr_f = !fd_f && ($urandom_range(0, 7) == 0);
            rec.raw_ident = {rtr_f, fd_f, ext_f,
                             ext_f ? 29'($urandom) : 29'($urandom_range(0, 'h7FF))};
            if (rtr_f) begin
              rec.payload_len = '0;
            end else if (!fd_f) begin
              rec.payload_len = cbrv_pkg::PLEN_W'($urandom_range(0, 8));
            end else begin
              pick = $urandom_range(0, 15);
              case (pick)
                9:       rec.payload_len = 8'd12;
                10:      rec.payload_len = 8'd16;
                11:      rec.payload_len = 8'd20;
                12:      rec.payload_len = 8'd24;
                13:      rec.payload_len = 8'd32;
                14:      rec.payload_len = 8'd48;
                15:      rec.payload_len = 8'd64;
                default: rec.payload_len = cbrv_pkg::PLEN_W'(pick);
              endcase
            end
            if (k == 0) rec.delta_ticks = '0;
          end
          total += cbrv_pkg::RECORD_BYTES + rec.payload_len;
          recs.push_back(rec);
        end
        // declared total mostly exact, sometimes short or long
        case ($urandom_range(0, 9))
          0:       hdr_len = cbrv_pkg::LEN_W'(total - $urandom_range(1, 8));
          1:       hdr_len = cbrv_pkg::LEN_W'(total + $urandom_range(1, 8));
          default: hdr_len = cbrv_pkg::LEN_W'(total);
        endcase
        keep = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : n;
        add_hdr(hdr_len, cbrv_pkg::COUNT_W'(n), {$urandom, $urandom});
        for (k = 0; k < keep; k++) outbound_items.push_back(recs[k]);
      end else if (mode < 92) begin
        outbound_items.push_back(random_item(cbrv_pkg::OP_HEADER));
      end else begin
        outbound_items.push_back(random_item(cbrv_pkg::OP_RECORD));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all items sent, all results back, then a short quiet period
    while (outbound_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
